### rtl/chi_pkg.sv
package chi_pkg;

	// Load enables for the three stages of the basis-weight pipeline.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} chi_stage_en_t;

endpackage

### rtl/chi_basis.sv
module chi_basis #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                              clk,
	input  chi_pkg::chi_stage_en_t            stage_en,
	input  logic        [FRACTION_BITS-1:0]   position,
	output logic signed [FRACTION_BITS+2:0]   h00,
	output logic signed [FRACTION_BITS+2:0]   h10,
	output logic signed [FRACTION_BITS+2:0]   h01,
	output logic signed [FRACTION_BITS+2:0]   h11
);
	import chi_pkg::*;

	localparam int F  = FRACTION_BITS;
	localparam int HW = F + 3;
	localparam logic [2*F-1:0] HALF = (2*F)'(1) << (F - 1);
	localparam logic signed [HW-1:0] ONE = HW'(1) <<< F;

	logic [2*F-1:0] sq;
	logic [2*F-1:0] cube;
	logic [F-1:0] t_s1, mu2_s1;
	logic [F-1:0] t_s2, mu2_s2, mu3_s2;
	logic signed [HW-1:0] tx, a2x, a3x;
	logic signed [HW-1:0] h00_s3, h10_s3, h01_s3, h11_s3;

	// Both products round to nearest, a tie going up; neither exceeds F bits.
	assign sq   = position * position + HALF;
	assign cube = mu2_s1 * t_s1 + HALF;

	always_ff @(posedge clk) begin
		if (stage_en.s1) begin
			t_s1   <= position;
			mu2_s1 <= sq[2*F-1:F];
		end
		if (stage_en.s2) begin
			t_s2   <= t_s1;
			mu2_s2 <= mu2_s1;
			mu3_s2 <= cube[2*F-1:F];
		end
		if (stage_en.s3) begin
			h00_s3 <= (a3x <<< 1) - a2x - (a2x <<< 1) + ONE;
			h10_s3 <= a3x - (a2x <<< 1) + tx;
			h01_s3 <= (a2x <<< 1) + a2x - (a3x <<< 1);
			h11_s3 <= a3x - a2x;
		end
	end

	assign tx  = signed'({3'b000, t_s2});
	assign a2x = signed'({3'b000, mu2_s2});
	assign a3x = signed'({3'b000, mu3_s2});

	assign h00 = h00_s3;
	assign h10 = h10_s3;
	assign h01 = h01_s3;
	assign h11 = h11_s3;

endmodule

### rtl/cubic_hermite_interpolator.sv
// Catmull-Rom cubic interpolator, six register stages from input transfer to result.
// Each input transfer is registered into stage one, and its result is offered from stage six.
// Throughput: one item per cycle while out_ready is high; every stage holds its data while
// the one after it is full and cannot load, so a stall drops or repeats nothing.
// Reset: arst_n low clears all stage valid bits at once; data registers are not reset.
module cubic_hermite_interpolator #(
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [SAMPLE_BITS-1:0]   sample_before,
	input  logic signed [SAMPLE_BITS-1:0]   sample_start,
	input  logic signed [SAMPLE_BITS-1:0]   sample_end,
	input  logic signed [SAMPLE_BITS-1:0]   sample_after,
	input  logic        [FRACTION_BITS-1:0] position,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [SAMPLE_BITS-1:0]   value,
	output logic                            clipped
);
	import chi_pkg::*;

	localparam int S  = SAMPLE_BITS;
	localparam int F  = FRACTION_BITS;
	// Basis weights are signed Q.F and stay within three times one in magnitude.
	localparam int HW = F + 3;
	// One weight times one sample or one sample difference.
	localparam int MW = HW + S + 1;
	// Partial sums, each holding two products, one of them doubled.
	localparam int SW = MW + 2;
	// The accumulator is in units of 2^-(F+1).
	localparam int AW = SW + 1;
	// Width after dropping the F+1 fraction bits.
	localparam int RW = AW - F - 1;

	localparam logic signed [SW-1:0] RND = SW'(1) <<< F;
	localparam logic signed [RW-1:0] HI  = {{(RW-S+1){1'b0}}, {(S-1){1'b1}}};
	localparam logic signed [RW-1:0] LO  = {{(RW-S+1){1'b1}}, {(S-1){1'b0}}};

	// Stage flow control. A stage loads when it is empty or when the stage after it
	// loads in the same cycle; this lets bubbles collapse while the output waits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	chi_stage_en_t basis_en;

	assign en_s6 = !v_s6 || out_ready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign in_ready  = en_s1;
	assign out_valid = v_s6;

	assign basis_en.s1 = en_s1;
	assign basis_en.s2 = en_s2;
	assign basis_en.s3 = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stages one to three: mu squared, mu cubed, then the four basis weights.
	logic signed [HW-1:0] h00_s3, h10_s3, h01_s3, h11_s3;

	chi_basis #(
		.FRACTION_BITS(F)
	) u_basis (
		.clk      (clk),
		.stage_en (basis_en),
		.position (position),
		.h00      (h00_s3),
		.h10      (h10_s3),
		.h01      (h01_s3),
		.h11      (h11_s3)
	);

	// The samples ride alongside. The tangent halves are folded into the sum: the
	// accumulator is twice the result, so the plain differences serve as tangents
	// and the two sample terms are doubled instead.
	logic signed [S:0] y1_s1, y2_s1, d0_s1, d1_s1;
	logic signed [S:0] y1_s2, y2_s2, d0_s2, d1_s2;
	logic signed [S:0] y1_s3, y2_s3, d0_s3, d1_s3;
	logic signed [MW-1:0] p00_s4, p10_s4, p01_s4, p11_s4;
	logic signed [SW-1:0] sa_s5, sb_s5;
	logic signed [AW-1:0] acc;
	logic signed [RW-1:0] rounded;
	logic signed [S-1:0]  value_s6;
	logic                 clipped_s6;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			y1_s1 <= (S+1)'(sample_start);
			y2_s1 <= (S+1)'(sample_end);
			d0_s1 <= (S+1)'(sample_end) - (S+1)'(sample_before);
			d1_s1 <= (S+1)'(sample_after) - (S+1)'(sample_start);
		end
		if (en_s2) begin
			y1_s2 <= y1_s1;
			y2_s2 <= y2_s1;
			d0_s2 <= d0_s1;
			d1_s2 <= d1_s1;
		end
		if (en_s3) begin
			y1_s3 <= y1_s2;
			y2_s3 <= y2_s2;
			d0_s3 <= d0_s2;
			d1_s3 <= d1_s2;
		end
		// Stage four: one multiply per term.
		if (en_s4) begin
			p00_s4 <= MW'(h00_s3) * MW'(y1_s3);
			p10_s4 <= MW'(h10_s3) * MW'(d0_s3);
			p01_s4 <= MW'(h01_s3) * MW'(y2_s3);
			p11_s4 <= MW'(h11_s3) * MW'(d1_s3);
		end
		// Stage five: two partial sums; the rounding half goes in here.
		if (en_s5) begin
			sa_s5 <= (SW'(p00_s4) <<< 1) + SW'(p10_s4) + RND;
			sb_s5 <= (SW'(p01_s4) <<< 1) + SW'(p11_s4);
		end
		// Stage six: final sum, floor shift, and saturation to the sample range.
		if (en_s6) begin
			priority if (rounded > HI) begin
				value_s6   <= HI[S-1:0];
				clipped_s6 <= 1'b1;
			end else if (rounded < LO) begin
				value_s6   <= LO[S-1:0];
				clipped_s6 <= 1'b1;
			end else begin
				value_s6   <= rounded[S-1:0];
				clipped_s6 <= 1'b0;
			end
		end
	end

	// The arithmetic shift floors, so with the half added this rounds a tie upward.
	assign acc     = AW'(sa_s5) + AW'(sb_s5);
	assign rounded = acc[AW-1:F+1];

	assign value   = value_s6;
	assign clipped = clipped_s6;

`ifndef ASSERT_OFF
	// A saturated result sits exactly on one of the two bounds.
	a_clip_on_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (value == HI[S-1:0]) || (value == LO[S-1:0]))
		else $error("clipped result is not on a range bound");

	// The input side stalls only when the first stage holds an item.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1)
		else $error("input stalled with an empty first stage");

	// A full stage four that cannot pass its item on keeps it and its products.
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !en_s5 |=> v_s4 && $stable(p00_s4) && $stable(p11_s4))
		else $error("stalled product stage lost or changed its item");

	// An item in stage five reaches the output register whenever stage six loads.
	a_s5_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && en_s6 |=> out_valid)
		else $error("item vanished between the last two stages");
`endif

endmodule

### verif/tb_cubic_hermite_interpolator.sv
`timescale 1ns / 1ps

module tb_cubic_hermite_interpolator;

	localparam int SB = 16;
	localparam int FB = 16;

	localparam longint UNIT = longint'(1) << FB;
	localparam longint HALF_LSB = longint'(1) << (FB - 1);
	localparam longint SAT_HI = (longint'(1) << (SB - 1)) - 1;
	localparam longint SAT_LO = -(longint'(1) << (SB - 1));

	localparam int RANDOM_ITEMS = 1200;
	// The sender stops after this many transfers and waits for the pipeline to drain.
	localparam int DRAIN_AT = 800;
	// Once this many results have arrived, the receiver refuses results for a long stretch.
	localparam int LONG_HOLD_AT = 300;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [SB-1:0] y_prev;
		logic signed [SB-1:0] y_start;
		logic signed [SB-1:0] y_end;
		logic signed [SB-1:0] y_next;
		logic [FB-1:0] pos;
	} sample_set_t;

	typedef struct {
		logic signed [SB-1:0] value;
		logic clipped;
	} interp_result_t;

	logic clk;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SB-1:0] sample_before = '0;
	logic signed [SB-1:0] sample_start = '0;
	logic signed [SB-1:0] sample_end = '0;
	logic signed [SB-1:0] sample_after = '0;
	logic [FB-1:0] position = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SB-1:0] value;
	logic clipped;

	cubic_hermite_interpolator #(
		.SAMPLE_BITS(SB),
		.FRACTION_BITS(FB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_before(sample_before),
		.sample_start(sample_start),
		.sample_end(sample_end),
		.sample_after(sample_after),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value),
		.clipped(clipped)
	);

	// Input sets waiting to be offered, and interpolated values waiting to come out.
	sample_set_t stim_q[$];
	interp_result_t interp_q[$];

	int fail_count = 0;
	int cycle_count = 0;
	int total_items = 0;

	// Counters written only by the monitor, with nonblocking assignments, so that every
	// other process sees the value from before the current clock edge.
	int inputs_seen = 0;
	int results_seen = 0;
	int results_owed = 0;

	// Driver-side bookkeeping.
	int items_sent = 0;
	int send_gap = 0;
	logic draining = 1'b0;
	logic drain_fresh;
	sample_set_t next_set;

	// Receiver-side bookkeeping.
	int ready_stall = 0;
	logic long_hold_done = 1'b0;
	int ready_roll;

	// Monitor-side scratch.
	sample_set_t taken_set;
	interp_result_t due;

	// Computes the Catmull-Rom interpolation in fixed point. The accumulator counts
	// units of 2^-(FB+1), so the half-weight tangents stay exact; the final arithmetic
	// shift is a floor, which together with the added half gives round-to-nearest with
	// ties going toward positive infinity.
	function automatic interp_result_t hermite_expected(sample_set_t s);
		longint y0, y1, y2, y3;
		longint t, mu2, mu3;
		longint h00, h10, h01, h11;
		longint acc, v;
		interp_result_t r;
		y0 = s.y_prev;
		y1 = s.y_start;
		y2 = s.y_end;
		y3 = s.y_next;
		t = longint'(s.pos);
		mu2 = (t * t + HALF_LSB) >>> FB;
		mu3 = (mu2 * t + HALF_LSB) >>> FB;
		h00 = 2 * mu3 - 3 * mu2 + UNIT;
		h10 = mu3 - 2 * mu2 + t;
		h01 = -2 * mu3 + 3 * mu2;
		h11 = mu3 - mu2;
		acc = 2 * h00 * y1;
		acc += h10 * (y2 - y0);
		acc += 2 * h01 * y2;
		acc += h11 * (y3 - y1);
		v = (acc + UNIT) >>> (FB + 1);
		r.clipped = 1'b0;
		if (v > SAT_HI) begin
			v = SAT_HI;
			r.clipped = 1'b1;
		end
		if (v < SAT_LO) begin
			v = SAT_LO;
			r.clipped = 1'b1;
		end
		r.value = v[SB-1:0];
		return r;
	endfunction

	function automatic logic signed [SB-1:0] clamp_sample(int x);
		if (x > SAT_HI)
			return SAT_HI[SB-1:0];
		if (x < SAT_LO)
			return SAT_LO[SB-1:0];
		return x[SB-1:0];
	endfunction

	function automatic logic signed [SB-1:0] extreme_sample();
		case ($urandom_range(0, 5))
			0: return SAT_HI[SB-1:0];
			1: return SAT_LO[SB-1:0];
			2: return SB'(SAT_HI - 1);
			3: return SB'(SAT_LO + 1);
			4: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic logic [FB-1:0] random_position();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			2: return FB'(1);
			3: return FB'(1 << (FB - 1));
			default: return FB'($urandom_range(0, (1 << FB) - 1));
		endcase
	endfunction

	// Builds one random sample set. Most sets either use full-range samples, which
	// often overshoot and clip, or a smooth neighborhood, which stays in range and
	// exercises the rounding; the rest sit on the extremes or near zero.
	function automatic sample_set_t random_set();
		sample_set_t s;
		int base;
		int spread;
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			s.y_prev = SB'($urandom_range(0, 65535));
			s.y_start = SB'($urandom_range(0, 65535));
			s.y_end = SB'($urandom_range(0, 65535));
			s.y_next = SB'($urandom_range(0, 65535));
		end else if (kind < 70) begin
			base = int'($urandom_range(0, 65535)) - 32768;
			spread = $urandom_range(1, 4000);
			s.y_prev = clamp_sample(base + int'($urandom_range(0, 2 * spread)) - spread);
			s.y_start = clamp_sample(base + int'($urandom_range(0, 2 * spread)) - spread);
			s.y_end = clamp_sample(base + int'($urandom_range(0, 2 * spread)) - spread);
			s.y_next = clamp_sample(base + int'($urandom_range(0, 2 * spread)) - spread);
		end else if (kind < 85) begin
			s.y_prev = extreme_sample();
			s.y_start = extreme_sample();
			s.y_end = extreme_sample();
			s.y_next = extreme_sample();
		end else begin
			s.y_prev = clamp_sample(int'($urandom_range(0, 64)) - 32);
			s.y_start = clamp_sample(int'($urandom_range(0, 64)) - 32);
			s.y_end = clamp_sample(int'($urandom_range(0, 64)) - 32);
			s.y_next = clamp_sample(int'($urandom_range(0, 64)) - 32);
		end
		s.pos = random_position();
		return s;
	endfunction

	task automatic add_set(int y0, int y1, int y2, int y3, int pos);
		sample_set_t s;
		s.y_prev = y0[SB-1:0];
		s.y_start = y1[SB-1:0];
		s.y_end = y2[SB-1:0];
		s.y_next = y3[SB-1:0];
		s.pos = pos[FB-1:0];
		stim_q.push_back(s);
	endtask

	// Gap before the next offer: usually none, sometimes short, rarely long.
	// Every fourth block of transfers runs back to back.
	function automatic int sender_gap(int sent);
		int r;
		if (((sent / 200) % 4) == 2)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog: a run that hangs or loses results ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Stimulus: a directed set first, then random sets. The same block then waits for
	// the pipeline to empty and reports the outcome.
	initial begin
		// At position zero the result must be exactly the interval start.
		add_set(0, 0, 0, 0, 0);
		add_set(1000, -2000, 3000, -4000, 0);
		add_set(32767, -32768, 32767, 32767, 0);
		add_set(-32768, 32767, -32768, -32768, 0);
		// Smallest and largest fractions.
		add_set(-32768, 32767, -32768, 32767, 1);
		add_set(-32768, 32767, -32768, 32767, 65535);
		add_set(0, 32767, 32767, 0, 65535);
		add_set(-1, -1, -1, -1, 65535);
		// Flat lines at both rails must not clip.
		add_set(32767, 32767, 32767, 32767, 32768);
		add_set(-32768, -32768, -32768, -32768, 32768);
		// Steep tangents push the curve past the rails: overshoot saturates and flags.
		add_set(-32768, 32767, 32767, -32768, 32768);
		add_set(32767, -32768, -32768, 32767, 32768);
		add_set(-32768, 32767, 32767, -32768, 49152);
		add_set(32767, -32768, -32768, 32767, 16384);
		// A straight ramp interpolates linearly.
		add_set(-3000, -1000, 1000, 3000, 16384);
		add_set(32767, 0, 0, -32768, 12345);
		// Alternating bit patterns on every field.
		add_set(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA);
		add_set(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555);
		add_set(1, -1, 1, -1, 16'h0001);
		add_set(-32767, 32766, -32767, 32766, 16'h7FFF);
		repeat (RANDOM_ITEMS)
			stim_q.push_back(random_set());
		total_items = stim_q.size();

		do
			@(posedge clk);
		while (inputs_seen != total_items || results_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Sender. A set stays on the inputs until its transfer; only then may the driver
	// go idle or put up the next set. Once DRAIN_AT transfers have gone, it holds off
	// until every outstanding result has come out.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
			draining = 1'b0;
		end else if (!in_valid || in_ready) begin
			drain_fresh = 1'b0;
			if (in_valid) begin
				items_sent = items_sent + 1;
				if (items_sent == DRAIN_AT) begin
					draining = 1'b1;
					drain_fresh = 1'b1;
				end
			end
			// The owed count does not yet include a transfer made on this edge, so it is not
			// trusted on the edge where the pause begins.
			if (draining && !drain_fresh && results_owed == 0)
				draining = 1'b0;
			if (draining) begin
				in_valid <= 1'b0;
			end else if (send_gap > 0) begin
				send_gap = send_gap - 1;
				in_valid <= 1'b0;
			end else if (stim_q.size() > 0) begin
				next_set = stim_q.pop_front();
				sample_before <= next_set.y_prev;
				sample_start <= next_set.y_start;
				sample_end <= next_set.y_end;
				sample_after <= next_set.y_next;
				position <= next_set.pos;
				in_valid <= 1'b1;
				send_gap = sender_gap(items_sent);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver. Ready drops at random, with calm stretches, and once for a long
	// hold-off while the sender keeps offering, so the pipeline fills and in_ready
	// falls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_stall = 0;
			long_hold_done = 1'b0;
		end else begin
			if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				ready_stall = LONG_HOLD_CYCLES;
			end
			if (ready_stall > 0) begin
				ready_stall = ready_stall - 1;
				out_ready <= 1'b0;
			end else if (((cycle_count / 400) % 4) == 1) begin
				out_ready <= 1'b1;
			end else begin
				ready_roll = $urandom_range(0, 99);
				if (ready_roll < 75) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					if (ready_roll < 96)
						ready_stall = $urandom_range(0, 2);
					else
						ready_stall = $urandom_range(8, 30);
				end
			end
		end
	end

	// Monitor. Checks each result transfer against the oldest prediction, then records
	// the prediction for an input transfer on the same edge. Both happen in this one
	// process, so the order of the queue never depends on scheduling.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inputs_seen <= 0;
			results_seen <= 0;
			results_owed <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (interp_q.size() == 0) begin
					$error("unexpected result: value %0d, clipped %0b", value, clipped);
					fail_count = fail_count + 1;
				end else begin
					due = interp_q.pop_front();
					if (value !== due.value) begin
						$error("value: expected %0d, actual %0d", due.value, value);
						fail_count = fail_count + 1;
					end
					if (clipped !== due.clipped) begin
						$error("clipped: expected %0b, actual %0b", due.clipped, clipped);
						fail_count = fail_count + 1;
					end
				end
				results_seen <= results_seen + 1;
			end
			if (in_valid && in_ready) begin
				taken_set.y_prev = sample_before;
				taken_set.y_start = sample_start;
				taken_set.y_end = sample_end;
				taken_set.y_next = sample_after;
				taken_set.pos = position;
				interp_q.push_back(hermite_expected(taken_set));
				inputs_seen <= inputs_seen + 1;
			end
			results_owed <= interp_q.size();
		end
	end

endmodule
